>>> rtl/scf_pkg.sv
// ----------------------------------------------------------------------------
// scf_pkg: shared types and constants of the square-root continued fraction unit
// Holds the field widths, the register map and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none
package scf_pkg;
   localparam int RadicandBitsDefault = 126;
   localparam int TermBits = 64;
   localparam int IndexBits = 6;
   localparam int HighBits = 62;
   localparam int CsrAddrBits = 2;
   localparam logic [CsrAddrBits-1:0] CSR_MAX_TERMS = 2'd0;
   localparam logic [IndexBits-1:0] MaxTermsReset = 6'd63;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ROOT_SQ,      // square the trial root bit by bit
      ST_ROOT_CMP,     // keep or drop the trial bit
      ST_A1_DIV,       // a1 = 2*a0 / c
      ST_EMIT0,
      ST_EMIT,
      ST_B_MUL,        // a*c, then b = a*c - b
      ST_C_MUL,        // b*b, then x - b*b
      ST_C_DIV,        // c = (x - b*b) / c
      ST_A_DIV         // a = (a0 + b) / c
   } seq_state_type;
endpackage
`default_nettype wire

>>> rtl/sqrt_continued_fraction.sv
// ----------------------------------------------------------------------------
// sqrt_continued_fraction: continued fraction expansion of a square root
// Bit-serial shift-and-add multiplier and restoring divider shared by all steps.
// ----------------------------------------------------------------------------
// Sequence: a bit-serial root search finds a0, which is emitted; a1 follows from a
//   divide, then each further term takes two multiplies and two divides; the run
//   time is set by the one shared bit-serial multiply/divide.
// Throughput: one radicand at a time; the next word is taken once the last
//   term has left the output register.
// Reset: synchronous, active high; clears control state and sets max_terms to 63.
`default_nettype none
module sqrt_continued_fraction #(
   parameter int RADICAND_BITS = scf_pkg::RadicandBitsDefault
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [scf_pkg::HighBits-1:0]     req_radicand_high,
   input  wire logic [scf_pkg::TermBits-1:0]     req_radicand_low,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [scf_pkg::TermBits-1:0]          rsp_partial_quotient,
   output logic [scf_pkg::IndexBits-1:0]         rsp_term_index,
   output logic                                  rsp_period_end,
   output logic                                  rsp_square_input,
   output logic                                  rsp_last,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [scf_pkg::CsrAddrBits-1:0]  paddr,
   input  wire logic [31:0]                      pwdata,
   output logic [31:0]                           prdata,
   output logic                                  pready
);
   import scf_pkg::*;

   localparam int W = TermBits;
   localparam int WW = 2 * TermBits;
   localparam int CW = $clog2(WW + 1);
   // radicand mask derived from the parameter
   localparam logic [WW-1:0] XMask = (RADICAND_BITS >= WW) ? {WW{1'b1}} :
      ((({{(WW-1){1'b0}}, 1'b1}) << RADICAND_BITS) - {{(WW-1){1'b0}}, 1'b1});

   seq_state_type state_ff, state_in;

   logic [IndexBits-1:0] max_terms_ff;
   logic [WW-1:0]  x_ff;
   logic [W-1:0]   a0_ff, b_ff, c_ff, a_ff;
   logic [IndexBits-1:0] idx_ff, idx_in;
   logic [5:0]     rbit_ff;          // trial bit of the root search
   logic [WW-1:0]  root_sq_ff, root_sq_in;   // square of the root kept so far

   // shared serial unit: multiplicand / divisor, multiplier / dividend shift, accumulator
   logic [WW-1:0]  acc_ff, acc_in;   // product, or dividend/quotient shift register
   logic [W:0]     rem_ff, rem_in;   // divider remainder (one extra bit for carry)
   logic [W-1:0]   opa_ff, opa_in;   // multiplicand or divisor
   logic [W-1:0]   opb_ff, opb_in;   // multiplier shift register
   logic [CW-1:0]  cnt_ff, cnt_in;

   logic [W-1:0]   a0_in, b_in, c_in, a_in;
   logic [5:0]     rbit_in;

   // output register
   logic           ov_ff, ov_in;
   logic [W-1:0]   oq_ff, oq_in;
   logic [IndexBits-1:0] oi_ff, oi_in;
   logic           ope_ff, ope_in, osq_ff, osq_in, olast_ff, olast_in;

   logic [W-1:0]   trial, two, quo;
   logic [WW-1:0]  rem_x;
   logic [W:0]     rsh, rdiff;
   logic [IndexBits-1:0] limit;
   logic           take_out, done_stop;

   assign pready = 1'b1;
   assign prdata = (paddr == CSR_MAX_TERMS) ? {26'd0, max_terms_ff} : 32'd0;
   assign req_stall = (state_ff != ST_IDLE) || ov_ff;
   assign take_out = ov_ff && !rsp_stall;

   assign trial = a0_ff | ({{(W-1){1'b0}}, 1'b1} << rbit_ff);
   assign two = {a0_ff[W-2:0], 1'b0};
   assign limit = (max_terms_ff == '0) ? {{(IndexBits-1){1'b0}}, 1'b1} : max_terms_ff;
   assign rem_x = x_ff - acc_ff;
   // restoring divide step: shift in the next dividend bit
   assign rsh = {rem_ff[W-1:0], acc_ff[WW-1]};
   assign rdiff = rsh - {1'b0, opa_ff};
   // quotient above 64 bits or zero divisor saturates
   assign quo = (opa_ff == '0 || acc_ff[WW-1:W] != '0) ? {W{1'b1}} : acc_ff[W-1:0];
   assign done_stop = (idx_ff >= limit) || (a_ff == two);

   always_ff @(posedge clock) begin
      if (reset) begin
         max_terms_ff <= MaxTermsReset;
      end else if (psel && penable && pwrite && paddr == CSR_MAX_TERMS) begin
         max_terms_ff <= pwdata[IndexBits-1:0];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_valid && !ov_ff) state_in = ST_ROOT_SQ;
         ST_ROOT_SQ: if (cnt_ff == CW'(W - 1)) state_in = ST_ROOT_CMP;
         ST_ROOT_CMP: begin
            if (rbit_ff == 6'd0) begin
               state_in = ST_EMIT0;
            end else begin
               state_in = ST_ROOT_SQ;
            end
         end
         ST_EMIT0: if (!ov_ff) state_in = (rem_x == '0) ? ST_IDLE : ST_A1_DIV;
         ST_A1_DIV: if (cnt_ff == CW'(WW)) state_in = ST_EMIT;
         ST_EMIT: if (!ov_ff) state_in = done_stop ? ST_IDLE : ST_B_MUL;
         ST_B_MUL: if (cnt_ff == CW'(W)) state_in = ST_C_MUL;
         ST_C_MUL: if (cnt_ff == CW'(W)) state_in = ST_C_DIV;
         ST_C_DIV: if (cnt_ff == CW'(WW)) state_in = ST_A_DIV;
         ST_A_DIV: if (cnt_ff == CW'(WW)) state_in = ST_EMIT;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      acc_in = acc_ff; rem_in = rem_ff; opa_in = opa_ff; opb_in = opb_ff;
      cnt_in = cnt_ff; a0_in = a0_ff; b_in = b_ff; c_in = c_ff; a_in = a_ff;
      idx_in = idx_ff; rbit_in = rbit_ff; root_sq_in = root_sq_ff;
      ov_in = ov_ff && !take_out;
      oq_in = oq_ff; oi_in = oi_ff; ope_in = ope_ff; osq_in = osq_ff; olast_in = olast_ff;
      case (state_ff)
         ST_IDLE: begin
            rbit_in = 6'd62;
            a0_in = '0;
            root_sq_in = '0;
            acc_in = '0;
            opb_in = {W{1'b0}} | ({{(W-1){1'b0}}, 1'b1} << 62);
            opa_in = {W{1'b0}} | ({{(W-1){1'b0}}, 1'b1} << 62);
            cnt_in = '0;
         end
         ST_ROOT_SQ: begin
            // add multiplicand when the low multiplier bit is set, then shift
            if (opb_ff[0]) acc_in = acc_ff + ({{W{1'b0}}, opa_ff} << cnt_ff[5:0]);
            opb_in = opb_ff >> 1;
            cnt_in = cnt_ff + 1'b1;
         end
         ST_ROOT_CMP: begin
            if (acc_ff <= x_ff) begin
               a0_in = trial;
               root_sq_in = acc_ff;
            end
            rbit_in = rbit_ff - 6'd1;
            acc_in = '0;
            cnt_in = '0;
            opa_in = (acc_ff <= x_ff ? trial : a0_ff) |
               ({{(W-1){1'b0}}, 1'b1} << (rbit_ff - 6'd1));
            opb_in = opa_in;
            if (rbit_ff == 6'd0) begin
               opa_in = acc_ff <= x_ff ? trial : a0_ff;
               opb_in = opa_in;
               cnt_in = CW'(W);
               // hand the square of the final root on to the remainder
               acc_in = (acc_ff <= x_ff) ? acc_ff : root_sq_ff;
            end
         end
         ST_EMIT0: begin
            // acc holds a0*a0, so rem_x is the remainder of the root search
            if (!ov_ff) begin
               ov_in = 1'b1; oq_in = a0_ff; oi_in = '0; ope_in = 1'b0;
               osq_in = (rem_x == '0); olast_in = (rem_x == '0);
               b_in = a0_ff; c_in = rem_x[W-1:0]; a_in = a0_ff; idx_in = '0;
               acc_in = {{(W-1){1'b0}}, two, 1'b0} >> 1;
               opa_in = rem_x[W-1:0];
               rem_in = '0; cnt_in = '0;
               if (rem_x == '0) c_in = '0;
            end
         end
         ST_A1_DIV, ST_C_DIV, ST_A_DIV: begin
            if (cnt_ff == CW'(WW)) begin
               rem_in = '0; cnt_in = '0;
               if (state_ff == ST_C_DIV) begin
                  c_in = quo;
                  acc_in = {{W{1'b0}}, a0_ff + b_ff};
                  opa_in = quo;
               end else begin
                  a_in = quo;
                  idx_in = idx_ff + 1'b1;
               end
            end else begin
               if (rem_ff[W] || rsh >= {1'b0, opa_ff}) begin
                  rem_in = rdiff;
                  acc_in = {acc_ff[WW-2:0], 1'b1};
               end else begin
                  rem_in = rsh;
                  acc_in = {acc_ff[WW-2:0], 1'b0};
               end
               if (rem_ff[W-1] && !rem_ff[W]) begin
                  rem_in = rsh - {1'b0, opa_ff};
                  acc_in = {acc_ff[WW-2:0], 1'b1};
               end
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (!ov_ff) begin
               ov_in = 1'b1; oq_in = a_ff; oi_in = idx_ff; ope_in = (a_ff == two);
               osq_in = 1'b0; olast_in = done_stop;
               acc_in = '0; opa_in = a_ff; opb_in = c_ff; cnt_in = '0;
            end
         end
         ST_B_MUL, ST_C_MUL: begin
            if (cnt_ff == CW'(W)) begin
               cnt_in = '0;
               if (state_ff == ST_B_MUL) begin
                  b_in = acc_ff[W-1:0] - b_ff;
                  acc_in = '0; opa_in = acc_ff[W-1:0] - b_ff;
                  opb_in = acc_ff[W-1:0] - b_ff;
               end else begin
                  acc_in = rem_x; opa_in = c_ff; rem_in = '0;
               end
            end else begin
               if (opb_ff[0]) acc_in = acc_ff + ({{W{1'b0}}, opa_ff} << cnt_ff[5:0]);
               opb_in = opb_ff >> 1;
               cnt_in = cnt_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ov_ff <= ov_in;
      end
   end

   // payload registers: capture the radicand on acceptance, advance the datapath
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid && !ov_ff) begin
         x_ff <= {2'b00, req_radicand_high, req_radicand_low} & XMask;
      end
      acc_ff <= acc_in; rem_ff <= rem_in; opa_ff <= opa_in; opb_ff <= opb_in;
      cnt_ff <= cnt_in; a0_ff <= a0_in; b_ff <= b_in; c_ff <= c_in; a_ff <= a_in;
      idx_ff <= idx_in; rbit_ff <= rbit_in; root_sq_ff <= root_sq_in;
      oq_ff <= oq_in; oi_ff <= oi_in; ope_ff <= ope_in; osq_ff <= osq_in;
      olast_ff <= olast_in;
   end

   assign rsp_valid = ov_ff;
   assign rsp_partial_quotient = oq_ff;
   assign rsp_term_index = oi_ff;
   assign rsp_period_end = ope_ff;
   assign rsp_square_input = osq_ff;
   assign rsp_last = olast_ff;
endmodule
`default_nettype wire
